>>> rtl/btf_pkg.sv
// Shared types, constants and codes for the bank tagged trace filter.
// Used by every module in rtl/ except btf_ram; depends on nothing.
package btf_pkg;

  localparam int NUM_RANGES = 16;
  localparam int RIDX_W     = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
  localparam int RAM_AW     = RIDX_W + 1;
  localparam int RAM_DEPTH  = 2 ** RAM_AW;
  localparam int CNT_W      = $clog2(NUM_RANGES + 1);
  localparam int CFG_W      = 5;
  localparam int LIM_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int ENTRY_W    = 32;

  localparam logic [15:0] WIN_LO     = 16'h4000;
  localparam logic [15:0] WIN_HI     = 16'hC000;
  localparam int          BANK_SHIFT = 13;
  localparam logic [15:0] PC_RESET   = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_BANK       = 3'd0,
    OP_FETCH      = 3'd1,
    OP_WRITE      = 3'd2,
    OP_LOAD_EXEC  = 3'd3,
    OP_LOAD_WATCH = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_FETCH = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_BANK  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CFG_TRACE_EN  = 3'd0,
    CFG_DEDUP_EN  = 3'd1,
    CFG_EXEC_CNT  = 3'd2,
    CFG_WATCH_CNT = 3'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic emit;
  } btf_cmd_t;

  typedef struct packed {
    logic go_scan;
    logic go_emit;
    logic more;
    logic rd_pend;
    logic pass;
    logic out_free;
  } btf_stat_t;

endpackage

>>> rtl/bank_tagged_trace_filter_top.sv
// Top level of the bank tagged trace filter: controller plus datapath.
// Depends on btf_pkg, btf_ctrl, btf_dp (and btf_ram through btf_dp).
//
// Usage:
//   Input channel in_* (valid/ready) carries CPU events: bank reports,
//   fetches, memory writes and range slot loads. Output channel out_*
//   (valid/ready) carries at most one trace record per input item.
//   cfg_we/cfg_index/cfg_wdata write one of the four control registers,
//   chosen by cfg_index; write them only while the filter is idle.
// Sequencing:
//   One item at a time. A range load, or an event dropped before any scan, ends with its accept.
//   A bank report goes from accept to the emit step. A fetch or write with n active ranges (n saturated at
//   NUM_RANGES) passes through these steps, the output load only when it emits:
//   accept, one range RAM read per cycle, one compare, one decide, one output load.
// Reset:
//   Synchronous, active low. Clears control registers but sets dedup enable,
//   clears range valid bits (unloaded slots read as zero), restores the bank
//   table to 0, 1, 2, 3 and the last emitted pc to none. No clearing pass.
// Stall:
//   A record waits in the output register; the next item is still taken,
//   and the filter holds in its emit step until the receiver takes the
//   previous record.
module bank_tagged_trace_filter_top
  import btf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_op,
  input  logic [15:0]      in_pc,
  input  logic [15:0]      in_addr,
  input  logic [7:0]       in_value,
  input  logic [1:0]       in_page,
  input  logic [7:0]       in_segment,
  input  logic [3:0]       in_slot,
  input  logic [15:0]      in_range_low,
  input  logic [15:0]      in_range_high,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_record_kind,
  output logic             out_segment_known,
  output logic [7:0]       out_record_segment,
  output logic [15:0]      out_record_pc,
  output logic [15:0]      out_record_addr,
  output logic [7:0]       out_record_value,
  output logic [1:0]       out_record_page
);

  btf_cmd_t  cmd;
  btf_stat_t st;

  btf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  btf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_op             (in_op),
    .in_pc             (in_pc),
    .in_addr           (in_addr),
    .in_value          (in_value),
    .in_page           (in_page),
    .in_segment        (in_segment),
    .in_slot           (in_slot),
    .in_range_low      (in_range_low),
    .in_range_high     (in_range_high),
    .cmd               (cmd),
    .st                (st),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_record_kind   (out_record_kind),
    .out_segment_known (out_segment_known),
    .out_record_segment(out_record_segment),
    .out_record_pc     (out_record_pc),
    .out_record_addr   (out_record_addr),
    .out_record_value  (out_record_value),
    .out_record_page   (out_record_page)
  );

endmodule

>>> rtl/btf_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module btf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/btf_ctrl.sv
// Controller state machine for the trace filter: accept, range scan, emit.
// Depends on btf_pkg; drives the datapath through btf_cmd_t.
module btf_ctrl
  import btf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  btf_stat_t st,
  output btf_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (st.go_scan) begin
            state_nxt = ST_SCAN;
          end else if (st.go_emit) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        if (!st.more && !st.rd_pend) begin
          state_nxt = st.pass ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.rd     = 1'b0;
    cmd.emit   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SCAN: cmd.rd   = st.more;
      ST_EMIT: cmd.emit = st.out_free;
      default: in_ready = 1'b0;
    endcase
  end

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !st.more && !st.rd_pend) |=> (state_r != ST_SCAN))
    else $error("scan did not terminate");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == ST_IDLE))
    else $error("emit not followed by idle");

endmodule

>>> rtl/btf_dp.sv
// Datapath: config registers, bank table, range RAM with valid bits,
// scan compare, dedup and output register. Depends on btf_pkg and btf_ram.
module btf_dp
  import btf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic [2:0]       in_op,
  input  logic [15:0]      in_pc,
  input  logic [15:0]      in_addr,
  input  logic [7:0]       in_value,
  input  logic [1:0]       in_page,
  input  logic [7:0]       in_segment,
  input  logic [3:0]       in_slot,
  input  logic [15:0]      in_range_low,
  input  logic [15:0]      in_range_high,
  input  btf_cmd_t         cmd,
  output btf_stat_t        st,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [1:0]       out_record_kind,
  output logic             out_segment_known,
  output logic [7:0]       out_record_segment,
  output logic [15:0]      out_record_pc,
  output logic [15:0]      out_record_addr,
  output logic [7:0]       out_record_value,
  output logic [1:0]       out_record_page
);

  logic             trace_en_r;
  logic             dedup_en_r;
  logic [CFG_W-1:0] exec_cnt_r;
  logic [CFG_W-1:0] watch_cnt_r;

  logic [7:0]  bank_seg_r [4];
  logic [15:0] last_pc_r;
  logic        last_vld_r;

  logic [2:0]  op_r;
  logic [15:0] pc_r;
  logic [15:0] addr_r;
  logic [7:0]  value_r;
  logic [1:0]  page_r;
  logic [7:0]  segment_r;

  logic [CNT_W-1:0]   idx_r;
  logic               rd_pend_r;
  logic               hit_r;
  logic               ent_vld_r;
  logic [RAM_DEPTH-1:0] vld_r;

  logic               out_valid_r;
  logic [1:0]         kind_r;
  logic               known_r;
  logic [7:0]         rseg_r;
  logic [15:0]        rpc_r;
  logic [15:0]        raddr_r;
  logic [7:0]         rvalue_r;
  logic [1:0]         rpage_r;

  logic               ram_we;
  logic [RAM_AW-1:0]  ram_waddr;
  logic [RAM_AW-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] entry;
  logic [15:0]        key;
  logic [CFG_W-1:0]   cnt;
  logic [LIM_W-1:0]   lim;
  logic               slot_ok;
  logic               known;
  logic [1:0]         bidx;
  logic               dup;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_en_r  <= 1'b0;
      dedup_en_r  <= 1'b1;
      exec_cnt_r  <= '0;
      watch_cnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRACE_EN:  trace_en_r  <= cfg_wdata[0];
        CFG_DEDUP_EN:  dedup_en_r  <= cfg_wdata[0];
        CFG_EXEC_CNT:  exec_cnt_r  <= cfg_wdata;
        CFG_WATCH_CNT: watch_cnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign slot_ok   = LIM_W'(in_slot) < LIM_W'(NUM_RANGES);
  assign ram_we    = cmd.accept && slot_ok &&
                     (in_op == OP_LOAD_EXEC || in_op == OP_LOAD_WATCH);
  assign ram_waddr = {in_op == OP_LOAD_WATCH, RIDX_W'(in_slot)};
  assign ram_raddr = {op_r == OP_WRITE, idx_r[RIDX_W-1:0]};

  btf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RAM_DEPTH)
  ) u_ranges (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({in_range_high, in_range_low}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_seg_r[0] <= 8'd0;
      bank_seg_r[1] <= 8'd1;
      bank_seg_r[2] <= 8'd2;
      bank_seg_r[3] <= 8'd3;
    end else if (cmd.accept && in_op == OP_BANK) begin
      bank_seg_r[in_page] <= in_segment;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_op;
      pc_r      <= in_pc;
      addr_r    <= in_addr;
      value_r   <= in_value;
      page_r    <= in_page;
      segment_r <= in_segment;
    end
    ent_vld_r <= vld_r[ram_raddr];
  end

  assign cnt   = (op_r == OP_FETCH) ? exec_cnt_r : watch_cnt_r;
  assign lim   = (LIM_W'(cnt) > LIM_W'(NUM_RANGES)) ? LIM_W'(NUM_RANGES) : LIM_W'(cnt);
  assign entry = ent_vld_r ? ram_rdata : '0;
  assign key   = (op_r == OP_FETCH) ? pc_r : addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd;
      if (cmd.accept) begin
        idx_r <= '0;
        hit_r <= 1'b0;
      end else begin
        if (cmd.rd) begin
          idx_r <= idx_r + 1'b1;
        end
        if (rd_pend_r && key >= entry[15:0] && key <= entry[31:16]) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  assign dup = (op_r == OP_FETCH) && dedup_en_r && last_vld_r && (pc_r == last_pc_r);

  assign st.go_scan  = trace_en_r &&
                       ((in_op == OP_FETCH && exec_cnt_r != '0) ||
                        (in_op == OP_WRITE && watch_cnt_r != '0));
  assign st.go_emit  = trace_en_r && (in_op == OP_BANK);
  assign st.more     = LIM_W'(idx_r) < lim;
  assign st.rd_pend  = rd_pend_r;
  assign st.pass     = hit_r && !dup;
  assign st.out_free = !out_valid_r || out_ready;

  assign known = (pc_r >= WIN_LO) && (pc_r < WIN_HI);
  assign bidx  = 2'((pc_r - WIN_LO) >> BANK_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pc_r  <= PC_RESET;
      last_vld_r <= 1'b0;
    end else if (cmd.emit && op_r == OP_FETCH) begin
      last_pc_r  <= pc_r;
      last_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (op_r)
        OP_BANK: begin
          kind_r   <= KIND_BANK;
          known_r  <= 1'b1;
          rseg_r   <= segment_r;
          rpc_r    <= '0;
          raddr_r  <= '0;
          rvalue_r <= '0;
          rpage_r  <= page_r;
        end
        OP_WRITE: begin
          kind_r   <= KIND_WRITE;
          known_r  <= known;
          rseg_r   <= known ? bank_seg_r[bidx] : 8'd0;
          rpc_r    <= pc_r;
          raddr_r  <= addr_r;
          rvalue_r <= value_r;
          rpage_r  <= '0;
        end
        default: begin
          kind_r   <= KIND_FETCH;
          known_r  <= known;
          rseg_r   <= known ? bank_seg_r[bidx] : 8'd0;
          rpc_r    <= pc_r;
          raddr_r  <= '0;
          rvalue_r <= '0;
          rpage_r  <= '0;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_record_kind    = kind_r;
  assign out_segment_known  = known_r;
  assign out_record_segment = rseg_r;
  assign out_record_pc      = rpc_r;
  assign out_record_addr    = raddr_r;
  assign out_record_value   = rvalue_r;
  assign out_record_page    = rpage_r;

  a_last_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && op_r == OP_FETCH) |=> (last_vld_r && last_pc_r == $past(pc_r)))
    else $error("last pc not updated by fetch record");

  a_no_pend_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !rd_pend_r)
    else $error("item accepted with range read in flight");

  a_pend_src: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(cmd.rd))
    else $error("range compare without a read");

endmodule
